// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// No dependencies; include by the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define NSV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Plain boolean condition checked at every clock edge outside reset.
`define NSV_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    `NSV_ASSERT(label, clk, rst_n, (expr), msg)

`endif

// ===== design/nsv_pkg.sv =====
// Package for the NMEA sentence validator: character codes, reject codes,
// line summary type and the judging functions. No dependencies.
`timescale 1ns / 1ps

package nsv_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_V      = 8'h56;

    localparam logic [7:0] RESET_MAX_LEN = 8'd200;
    localparam logic [7:0] MIN_LEN       = 8'd6;

    typedef enum logic [2:0] {
        RSN_OK       = 3'd0,
        RSN_SHORT    = 3'd1,
        RSN_NO_ID    = 3'd2,
        RSN_NO_CKSUM = 3'd3,
        RSN_BAD_HEX  = 3'd4,
        RSN_MISMATCH = 3'd5
    } t_reason;

    typedef struct packed {
        logic [7:0]  char_count;
        logic        starts_with_dollar;
        logic        star_seen;
        logic [7:0]  star_position;
        logic [7:0]  running_xor;
        logic        id_seen;
        logic [15:0] recent_chars;
        logic [15:0] checksum_chars;
    } t_line_state;

    typedef struct packed {
        logic       valid;
        logic       sentence_ok;
        t_reason    reason;
        logic [7:0] checksum;
        logic [7:0] length;
    } t_result;

    function automatic logic window_is_id(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
        logic hit;
        hit = (a == CH_G && b == CH_G && c == CH_A)
           || (a == CH_R && b == CH_M && c == CH_C)
           || (a == CH_G && b == CH_S && (c == CH_A || c == CH_V));
        return hit;
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

    function automatic t_reason judge(input t_line_state s);
        logic [4:0] hi;
        logic [4:0] lo;
        t_reason    r;
        hi = hex_digit(s.checksum_chars[15:8]);
        lo = hex_digit(s.checksum_chars[7:0]);
        if (s.char_count < MIN_LEN || !s.starts_with_dollar) begin
            r = RSN_SHORT;
        end else if (!s.id_seen) begin
            r = RSN_NO_ID;
        end else if (!s.star_seen ||
                     ({1'b0, s.star_position} + 9'd2) >= {1'b0, s.char_count}) begin
            r = RSN_NO_CKSUM;
        end else if (!hi[4] || !lo[4]) begin
            r = RSN_BAD_HEX;
        end else if ({hi[3:0], lo[3:0]} != s.running_xor) begin
            r = RSN_MISMATCH;
        end else begin
            r = RSN_OK;
        end
        return r;
    endfunction

endpackage

// ===== design/nsv_input_stage.sv =====
// Input register of the NMEA sentence validator with its stall logic.
// Depends on nsv_pkg.
`timescale 1ns / 1ps

module nsv_input_stage
    import nsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    output logic       o_stall,
    input  logic       i_out_free,
    output logic       o_take,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;

    // Only a newline produces a result, so only it waits for the output slot.
    assign o_take  = r_valid && ((r_byte != CH_LF) || i_out_free);
    assign o_stall = r_valid && !o_take;
    assign o_byte  = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (!o_stall) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_data_byte;
        end
    end

endmodule

// ===== design/nsv_line_tracker.sv =====
// Running line summary of the NMEA sentence validator and the verdict on newline.
// Depends on nsv_pkg.
`timescale 1ns / 1ps

module nsv_line_tracker
    import nsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_max_len,
    output t_result    o_result
);

    t_line_state r_state;
    t_line_state n_state;
    t_line_state s_app;
    logic [8:0]  w_pos_p1;
    logic [8:0]  w_pos_p2;

    assign w_pos_p1 = {1'b0, r_state.star_position} + 9'd1;
    assign w_pos_p2 = {1'b0, r_state.star_position} + 9'd2;

    always_comb begin
        s_app = r_state;
        if (r_state.char_count == 8'd0 && i_byte == CH_DOLLAR) begin
            s_app.starts_with_dollar = 1'b1;
        end
        if (r_state.char_count >= 8'd2 &&
            window_is_id(r_state.recent_chars[15:8], r_state.recent_chars[7:0], i_byte)) begin
            s_app.id_seen = 1'b1;
        end
        if (r_state.star_seen) begin
            if ({1'b0, r_state.char_count} == w_pos_p1) begin
                s_app.checksum_chars[15:8] = i_byte;
            end else if ({1'b0, r_state.char_count} == w_pos_p2) begin
                s_app.checksum_chars[7:0] = i_byte;
            end
        end else if (i_byte == CH_STAR) begin
            s_app.star_seen     = 1'b1;
            s_app.star_position = r_state.char_count;
        end else if (r_state.char_count != 8'd0) begin
            s_app.running_xor = r_state.running_xor ^ i_byte;
        end
        s_app.recent_chars = {r_state.recent_chars[7:0], i_byte};
        s_app.char_count   = r_state.char_count + 8'd1;
    end

    always_comb begin
        n_state = r_state;
        if (i_take) begin
            if (i_byte == CH_LF) begin
                n_state = '0;
            end else if (i_byte != CH_CR && r_state.char_count < i_max_len) begin
                n_state = s_app;
            end
        end
    end

    always_comb begin
        o_result.valid       = i_take && (i_byte == CH_LF);
        o_result.reason      = judge(r_state);
        o_result.sentence_ok = (o_result.reason == RSN_OK);
        o_result.checksum    = r_state.running_xor;
        o_result.length      = r_state.char_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/nsv_output_stage.sv =====
// Result register of the NMEA sentence validator.
// Depends on nsv_pkg.
`timescale 1ns / 1ps

module nsv_output_stage
    import nsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_result    i_result,
    output logic       o_free,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_sentence_ok,
    output logic [2:0] o_reject_reason,
    output logic [7:0] o_computed_checksum,
    output logic [7:0] o_line_length
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_result.valid) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid             = r_valid;
    assign o_sentence_ok       = r_result.sentence_ok;
    assign o_reject_reason     = r_result.reason;
    assign o_computed_checksum = r_result.checksum;
    assign o_line_length       = r_result.length;

endmodule

// ===== design/nmea_sentence_validator.sv =====
// NMEA sentence validator: one byte per cycle unless stalled, verdict on each newline.
// A newline sits in the input register; its verdict then goes to the result register.
// Throughput: one byte per cycle; only a newline waits, and only on a held result.
// Reset (synchronous, active low) empties both stages, clears the line summary
// and sets the line cap to 200.
`timescale 1ns / 1ps

module nmea_sentence_validator
    import nsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_max_line_length,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_sentence_ok,
    output logic [2:0] o_reject_reason,
    output logic [7:0] o_computed_checksum,
    output logic [7:0] o_line_length
);

    logic [7:0] r_max_line_length;
    logic       w_take;
    logic [7:0] w_byte;
    logic       w_out_free;
    t_result    w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line_length <= RESET_MAX_LEN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_line_length <= i_max_line_length;
        end
    end

    nsv_input_stage u_input (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .o_stall     (o_stall),
        .i_out_free  (w_out_free),
        .o_take      (w_take),
        .o_byte      (w_byte)
    );

    nsv_line_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_byte    (w_byte),
        .i_max_len (r_max_line_length),
        .o_result  (w_result)
    );

    nsv_output_stage u_output (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_result            (w_result),
        .o_free              (w_out_free),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_sentence_ok       (o_sentence_ok),
        .o_reject_reason     (o_reject_reason),
        .o_computed_checksum (o_computed_checksum),
        .o_line_length       (o_line_length)
    );

endmodule

// ===== design/nsv_checker.sv =====
// Port-level checker for the NMEA sentence validator, bound to the top level.
// Depends on nsv_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nsv_checker
    import nsv_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_sentence_ok,
    input logic [2:0] o_reject_reason,
    input logic [7:0] o_computed_checksum,
    input logic [7:0] o_line_length
);

    // The ok flag and the reason code must tell the same story.
    `NSV_ASSERT(a_ok_matches_reason, i_clk, i_rst_n, o_valid |-> (o_sentence_ok == (o_reject_reason == RSN_OK)), "sentence_ok disagrees with reject_reason")

    `NSV_ASSERT(a_reason_in_range, i_clk, i_rst_n, o_valid |-> (o_reject_reason <= RSN_MISMATCH), "reject_reason out of range")

    // An accepted sentence always has at least the minimum length.
    `NSV_ASSERT(a_ok_needs_length, i_clk, i_rst_n, (o_valid && o_sentence_ok) |-> (o_line_length >= MIN_LEN), "accepted sentence shorter than minimum")

    `NSV_ASSERT(a_hold_when_stalled, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_computed_checksum) && $stable(o_line_length)), "result changed while stalled")

endmodule

bind nmea_sentence_validator nsv_checker u_nsv_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_sentence_ok       (o_sentence_ok),
    .o_reject_reason     (o_reject_reason),
    .o_computed_checksum (o_computed_checksum),
    .o_line_length       (o_line_length)
);

// ===== bench/nmea_sentence_validator_tb.sv =====
// Self-checking testbench for nmea_sentence_validator: drives serial bytes and line caps,
// predicts each line verdict and compares it field by field. Depends on nsv_pkg and the RTL.
`timescale 1ns / 1ps

module nmea_sentence_validator_tb;
    import nsv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_BYTES    = 110;

    typedef struct {
        logic       ok;
        t_reason    reason;
        logic [7:0] checksum;
        logic [7:0] length;
    } t_verdict;

    // Tracks the line summary as the block should, and holds the verdicts still owed.
    class t_sentence_judge;
        t_line_state line;
        logic [7:0]  max_len;
        t_verdict    pending_verdicts[$];
        int          errors;
        int          bytes_seen;
        int          reason_hits[6];

        function new();
            line       = '0;
            max_len    = RESET_MAX_LEN;
            errors     = 0;
            bytes_seen = 0;
            foreach (reason_hits[k]) reason_hits[k] = 0;
        endfunction

        function int hex_nibble(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            return -1;
        endfunction

        function void take_byte(logic [7:0] c);
            t_verdict   v;
            int         hi;
            int         lo;
            logic [7:0] older;
            logic [7:0] prev;
            bytes_seen++;
            if (c == CH_LF) begin
                hi = hex_nibble(line.checksum_chars[15:8]);
                lo = hex_nibble(line.checksum_chars[7:0]);
                if (line.char_count < MIN_LEN || !line.starts_with_dollar) begin
                    v.reason = RSN_SHORT;
                end else if (!line.id_seen) begin
                    v.reason = RSN_NO_ID;
                end else if (!line.star_seen ||
                             int'(line.star_position) + 2 >= int'(line.char_count)) begin
                    v.reason = RSN_NO_CKSUM;
                end else if (hi < 0 || lo < 0) begin
                    v.reason = RSN_BAD_HEX;
                end else if (((hi << 4) | lo) != int'(line.running_xor)) begin
                    v.reason = RSN_MISMATCH;
                end else begin
                    v.reason = RSN_OK;
                end
                v.ok       = (v.reason == RSN_OK);
                v.checksum = line.running_xor;
                v.length   = line.char_count;
                pending_verdicts = {pending_verdicts, v};
                reason_hits[v.reason]++;
                line = '0;
            end else if (c != CH_CR && line.char_count < max_len) begin
                older = line.recent_chars[15:8];
                prev  = line.recent_chars[7:0];
                if (line.char_count == 0 && c == CH_DOLLAR) line.starts_with_dollar = 1'b1;
                if (line.char_count >= 2 &&
                    ((older == CH_G && prev == CH_G && c == CH_A) ||
                     (older == CH_R && prev == CH_M && c == CH_C) ||
                     (older == CH_G && prev == CH_S && (c == CH_A || c == CH_V))))
                    line.id_seen = 1'b1;
                // Once the first star is in, only the two characters after it are captured.
                if (line.star_seen) begin
                    if (int'(line.char_count) == int'(line.star_position) + 1)
                        line.checksum_chars[15:8] = c;
                    else if (int'(line.char_count) == int'(line.star_position) + 2)
                        line.checksum_chars[7:0] = c;
                end else if (c == CH_STAR) begin
                    line.star_seen     = 1'b1;
                    line.star_position = line.char_count;
                end else if (line.char_count >= 1) begin
                    line.running_xor = line.running_xor ^ c;
                end
                line.recent_chars = {prev, c};
                line.char_count   = line.char_count + 8'd1;
            end
        endfunction

        function void check_verdict(logic ok, logic [2:0] reason, logic [7:0] cksum,
                                    logic [7:0] len);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                $error("verdict with none expected: reason %0d, length %0d", reason, len);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (ok !== want.ok) begin
                $error("sentence_ok: expected %0d, actual %0d", want.ok, ok);
                errors++;
            end
            if (reason !== want.reason) begin
                $error("reject_reason: expected %0d, actual %0d", want.reason, reason);
                errors++;
            end
            if (cksum !== want.checksum) begin
                $error("computed_checksum: expected 0x%02h, actual 0x%02h", want.checksum, cksum);
                errors++;
            end
            if (len !== want.length) begin
                $error("line_length: expected %0d, actual %0d", want.length, len);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_valid           = 1'b0;
    logic [7:0] i_data_byte       = 8'd0;
    logic       i_cfg_valid       = 1'b0;
    logic [7:0] i_max_line_length = RESET_MAX_LEN;
    logic       i_stall           = 1'b0;
    logic       o_stall;
    logic       o_cfg_ready;
    logic       o_valid;
    logic       o_sentence_ok;
    logic [2:0] o_reject_reason;
    logic [7:0] o_computed_checksum;
    logic [7:0] o_line_length;

    t_sentence_judge board;
    bit            calm_sender = 1'b0;
    int            stall_left  = 0;
    int            stall_roll;
    int            quiet_cycles = 0;
    int            caps_written = 0;
    int            phase_start;
    logic [7:0]    cap_plan [8];

    nmea_sentence_validator dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_data_byte         (i_data_byte),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_max_line_length   (i_max_line_length),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_sentence_ok       (o_sentence_ok),
        .o_reject_reason     (o_reject_reason),
        .o_computed_checksum (o_computed_checksum),
        .o_line_length       (o_line_length)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Result side: check each accepted verdict, then pick the next stall burst.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_verdict(o_sentence_ok, o_reject_reason, o_computed_checksum,
                                o_line_length);
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 50) begin
                i_stall    <= 1'b0;
                stall_left <= $urandom_range(0, 4);
            end else if (stall_roll < 56) begin
                i_stall    <= 1'b0;
                stall_left <= $urandom_range(30, 80);
            end else if (stall_roll < 93) begin
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                i_stall    <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles, %0d verdicts outstanding",
                   WATCHDOG_LIMIT, board.pending_verdicts.size());
            $display("nmea_sentence_validator_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10) return 8'h30 + n;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    // Valid is lowered only for a real gap, so a back-to-back transaction keeps it high.
    task automatic send_byte(input logic [7:0] b);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (calm_sender || roll < 60) gap = 0;
        else if (roll < 93) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.take_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
        // A trailing carriage return or dropped byte may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_cap(input logic [7:0] cap);
        i_cfg_valid       <= 1'b1;
        i_max_line_length <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.max_len = cap;
        i_cfg_valid  <= 1'b0;
        caps_written++;
    endtask

    // Mostly well-formed sentences with random content; the rest are broken on purpose
    // at one check each, or plain noise over the full byte range.
    task automatic send_sentence();
        logic [7:0]  text[$];
        logic [7:0]  sum;
        logic [7:0]  c;
        logic [23:0] id;
        int          kind;
        int          keep;
        kind        = $urandom_range(0, 99);
        calm_sender = ($urandom_range(0, 4) == 0);
        if (kind >= 90) begin
            repeat ($urandom_range(1, 24)) text = {text, 8'($urandom_range(0, 255))};
            if ($urandom_range(0, 1)) text = {text, CH_LF};
        end else begin
            text = {text, CH_DOLLAR};
            repeat (2) text = {text, 8'($urandom_range("A", "Z"))};
            case ($urandom_range(0, 3))
                0: id = {CH_G, CH_G, CH_A};
                1: id = {CH_R, CH_M, CH_C};
                2: id = {CH_G, CH_S, CH_A};
                default: id = {CH_G, CH_S, CH_V};
            endcase
            // Lowercase letters never match a sentence id.
            if (kind >= 80 && kind < 85) id = id ^ 24'h202020;
            for (int k = 2; k >= 0; k--) text = {text, id[k*8 +: 8]};
            repeat ($urandom_range(0, 30)) begin
                c = ($urandom_range(0, 5) == 0) ? 8'h2C : 8'($urandom_range(8'h20, 8'h7E));
                if (c == CH_STAR) c = 8'h2C;
                text = {text, c};
            end
            sum = 8'd0;
            for (int k = 1; k < text.size(); k++) sum = sum ^ text[k];
            if (kind >= 60 && kind < 70) sum = sum ^ 8'($urandom_range(1, 255));
            text = {text, CH_STAR};
            text = {text, hex_char(sum[7:4])};
            text = {text, hex_char(sum[3:0])};
            if (kind >= 70 && kind < 75) begin
                text[text.size() - 1 - $urandom_range(0, 1)] = 8'($urandom_range(8'h20, 8'h7E));
            end else if (kind >= 75 && kind < 80) begin
                repeat ($urandom_range(1, 3)) void'(text.pop_back());
            end else if (kind >= 85) begin
                if ($urandom_range(0, 1)) begin
                    text[0] = 8'($urandom_range(8'h20, 8'h7E));
                end else begin
                    keep = $urandom_range(1, 5);
                    while (text.size() > keep) void'(text.pop_back());
                end
            end
            text = {text, CH_LF};
        end
        foreach (text[k]) begin
            if (text[k] == CH_LF && $urandom_range(0, 1)) send_byte(CH_CR);
            else if ($urandom_range(0, 24) == 0) send_byte(CH_CR);
            send_byte(text[k]);
        end
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines at the reset cap: an empty line (too short), a good sentence with carriage
        // returns and lowercase hex, then one line for each other reject reason.
        send_byte(CH_LF);
        send_text("$RM");
        send_byte(CH_CR);
        send_text("C*5c");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("$GSA*56\n");
        send_text("$");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("345\n");
        send_text("$GGA,*4\n");
        send_text("$GGA*G1\n");

        cap_plan = '{8'd255, 8'd6, 8'd0, 8'd5, 8'($urandom_range(7, 30)), RESET_MAX_LEN,
                     8'($urandom_range(6, 255)), 8'd255};
        foreach (cap_plan[p]) begin
            drain();
            write_line_cap(cap_plan[p]);
            phase_start = board.bytes_seen;
            while (board.bytes_seen - phase_start < PHASE_BYTES) send_sentence();
            // Leave a partial line open so the next cap change lands mid-line.
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
        end
        send_byte(CH_LF);

        drain();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d bytes under %0d line caps; %0d verdicts, %0d of them valid.",
                 board.bytes_seen, caps_written + 1,
                 board.reason_hits.sum(), board.reason_hits[RSN_OK]);
        $display("Rejects: short %0d, no id %0d, no checksum %0d, bad hex %0d, mismatch %0d.",
                 board.reason_hits[RSN_SHORT], board.reason_hits[RSN_NO_ID],
                 board.reason_hits[RSN_NO_CKSUM], board.reason_hits[RSN_BAD_HEX],
                 board.reason_hits[RSN_MISMATCH]);
        if (board.errors == 0) begin
            $display("nmea_sentence_validator_tb: PASS");
        end else begin
            $display("nmea_sentence_validator_tb: FAIL");
        end
        $finish;
    end

endmodule
